FILE: sv/sliding_window_mode_filter_top_assert.svh
// Assertion macros used by the port checker of this block.
`ifndef SLIDING_WINDOW_MODE_FILTER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MODE_FILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/swmf_pkg.sv
package swmf_pkg;

  localparam int WINDOW_SIZE = 5;
  localparam int HALF_SPAN   = WINDOW_SIZE / 2;
  localparam int FULL_SPAN   = 2 * HALF_SPAN + 1;
  localparam int NUM_CODES   = 8;

  localparam int CODE_W   = 4;
  localparam int FILL_W   = $clog2(FULL_SPAN + 1);
  localparam int CENTER_W = $clog2(HALF_SPAN + 1);
  localparam int TALLY_W  = $clog2(FULL_SPAN + 1);

  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [CENTER_W-1:0] center_t;
  typedef logic [TALLY_W-1:0]  tally_t;

  // Window contents, newest sample at index 0, and how many samples are held.
  typedef struct packed {
    code_t [FULL_SPAN-1:0] win;
    fill_t                 fill;
  } snap_t;

  // What the job register offers toward the output stage and the input side.
  typedef struct packed {
    logic  valid;
    logic  can_accept;
    code_t smoothed;
    logic  end_of_run;
  } seq_out_t;

endpackage

FILE: sv/swmf_window.sv
module swmf_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  swmf_pkg::code_t direction,
  input  logic            is_last,
  output swmf_pkg::snap_t snap_next
);
  import swmf_pkg::*;

  code_t [FULL_SPAN-1:0] win;
  fill_t                 fill;
  code_t                 clean;

  // Codes above the valid range are stored as zero so they never count.
  assign clean = (direction > CODE_W'(NUM_CODES)) ? '0 : direction;

  always_comb begin
    snap_next.win[0] = clean;
    for (int a = 1; a < FULL_SPAN; a++) begin
      snap_next.win[a] = win[a-1];
    end
    snap_next.fill = (fill < FILL_W'(FULL_SPAN)) ? fill + FILL_W'(1) : fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= '0;
      fill <= '0;
    end else if (accept) begin
      if (is_last) begin
        // Sequence ends: start the next one from an empty window.
        win  <= '0;
        fill <= '0;
      end else begin
        win  <= snap_next.win;
        fill <= snap_next.fill;
      end
    end
  end

endmodule

FILE: sv/swmf_mode.sv
module swmf_mode (
  input  swmf_pkg::snap_t   snap,
  input  swmf_pkg::center_t center,
  output swmf_pkg::code_t   mode
);
  import swmf_pkg::*;

  fill_t                  reach;
  fill_t                  newest_held;
  fill_t                  limit;
  logic [FULL_SPAN-1:0]   in_win;
  logic [FULL_SPAN-1:0]   hit [NUM_CODES];
  tally_t                 tally [NUM_CODES];
  tally_t                 best_count;
  code_t                  best;

  // Window runs from age 0 to center + half span, clipped to the oldest held.
  assign reach       = FILL_W'(center) + FILL_W'(HALF_SPAN);
  assign newest_held = snap.fill - FILL_W'(1);
  assign limit       = (reach < newest_held) ? reach : newest_held;

  always_comb begin
    for (int a = 0; a < FULL_SPAN; a++) begin
      in_win[a] = (FILL_W'(a) <= limit);
    end
    for (int k = 0; k < NUM_CODES; k++) begin
      for (int a = 0; a < FULL_SPAN; a++) begin
        hit[k][a] = in_win[a] && (snap.win[a] == CODE_W'(k + 1));
      end
      tally[k] = TALLY_W'($countones(hit[k]));
    end
  end

  // Strictly greater wins, so the smallest code keeps a tie.
  always_comb begin
    best_count = '0;
    best       = '0;
    for (int k = 0; k < NUM_CODES; k++) begin
      if (tally[k] > best_count) begin
        best_count = tally[k];
        best       = CODE_W'(k + 1);
      end
    end
  end

  assign mode = best;

endmodule

FILE: sv/swmf_seq.sv
module swmf_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               is_last,
  input  swmf_pkg::snap_t    snap_next,
  input  logic               result_ready,
  output swmf_pkg::seq_out_t seq_out
);
  import swmf_pkg::*;

  logic    job_valid;
  logic    job_last;
  center_t job_center;
  snap_t   job_snap;
  logic    job_final;
  logic    job_move;
  code_t   job_code;
  center_t flush_center;

  swmf_mode u_mode (
    .snap   (job_snap),
    .center (job_center),
    .mode   (job_code)
  );

  assign job_final = !job_last || (job_center == '0);
  assign job_move  = job_valid && result_ready;

  // Oldest pending result on a flush sits at min(fill, half span + 1) - 1.
  assign flush_center = (snap_next.fill > FILL_W'(HALF_SPAN)) ?
                        CENTER_W'(HALF_SPAN) :
                        CENTER_W'(snap_next.fill - FILL_W'(1));

  assign seq_out.valid      = job_valid;
  assign seq_out.can_accept = !job_valid || (job_move && job_final);
  assign seq_out.smoothed   = job_code;
  assign seq_out.end_of_run = job_last && (job_center == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= is_last || (snap_next.fill >= FILL_W'(HALF_SPAN + 1));
    end else if (job_move && job_final) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_snap   <= snap_next;
      job_last   <= is_last;
      job_center <= is_last ? flush_center : CENTER_W'(HALF_SPAN);
    end else if (job_move && !job_final) begin
      job_center <= job_center - CENTER_W'(1);
    end
  end

endmodule

FILE: sv/sliding_window_mode_filter_top.sv
// Path: each result passes from the job register through the result register to the ports.
// Throughput: one sample per cycle while the output is not stalled; after a last beat
//   sample_stall holds while the job register steps through the pending flush results.
// Reset (rst, synchronous, active high): empties the window, the job and the output.
module sliding_window_mode_filter_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_stall,
  input  swmf_pkg::code_t direction,
  input  logic            is_last,
  output logic            result_valid,
  input  logic            result_stall,
  output swmf_pkg::code_t smoothed,
  output logic            end_of_run
);
  import swmf_pkg::*;

  logic     accept;
  logic     result_ready;
  snap_t    snap_next;
  seq_out_t seq_out;

  // A beat lands when the job register is empty or hands off its final result.
  assign sample_stall = !seq_out.can_accept;
  assign accept       = sample_valid && !sample_stall;

  // Output register takes a new result when empty or when its beat is taken.
  assign result_ready = !result_valid || !result_stall;

  // Window shift line and fill count: advance on every accepted beat,
  // drop back to empty after a last beat.
  swmf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .direction (direction),
    .is_last   (is_last),
    .snap_next (snap_next)
  );

  // Job register: hold a snapshot of the window and step through the
  // centers that still need a result, one per cycle toward the output while it takes them.
  swmf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .is_last      (is_last),
    .snap_next    (snap_next),
    .result_ready (result_ready),
    .seq_out      (seq_out)
  );

  // Result register: parts the output handshake from the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_ready) begin
      result_valid <= seq_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ready) begin
      smoothed   <= seq_out.smoothed;
      end_of_run <= seq_out.end_of_run;
    end
  end

endmodule

FILE: sv/swmf_port_checker.sv
module swmf_port_checker (
  input logic            clk,
  input logic            rst,
  input logic            sample_valid,
  input logic            sample_stall,
  input swmf_pkg::code_t direction,
  input logic            is_last,
  input logic            result_valid,
  input logic            result_stall,
  input swmf_pkg::code_t smoothed,
  input logic            end_of_run
);
  import swmf_pkg::*;

  `include "sliding_window_mode_filter_top_assert.svh"

  // The winning code always comes from the valid range or is zero.
  `SWMF_ASSERT_NOW(a_code_range, clk, rst, result_valid,
                   smoothed <= CODE_W'(NUM_CODES), "smoothed out of range")

  // Input is held back only while the job register still owes a result,
  // so a result beat is waiting on the output next cycle.
  `SWMF_ASSERT_NEXT(a_stall_feeds_out, clk, rst, sample_stall, result_valid,
                    "input stalled with no result coming")

  // A stalled result beat holds.
  `SWMF_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall,
                    result_valid && $stable(smoothed) && $stable(end_of_run),
                    "stalled result changed")

  // A stalled sample beat holds.
  `SWMF_ASSERT_NEXT(a_sample_holds, clk, rst, sample_valid && sample_stall,
                    sample_valid && $stable(direction) && $stable(is_last),
                    "stalled sample changed")

endmodule

bind sliding_window_mode_filter_top swmf_port_checker u_port_checker (.*);

FILE: tb/sv/mode_filter_checker.sv
`timescale 1ns / 1ps

// Watch both channels, predict the smoothed codes of every sample beat and
// compare each result beat against the oldest prediction.
module mode_filter_checker
  import swmf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  sample_valid,
  input  logic  sample_stall,
  input  code_t direction,
  input  logic  is_last,
  input  logic  result_valid,
  input  logic  result_stall,
  input  code_t smoothed,
  input  logic  end_of_run,
  output int    fail_count,
  output int    pending
);

  typedef struct {
    code_t smoothed;
    logic  end_of_run;
  } smoothed_beat_t;

  code_t          window_q [FULL_SPAN];
  int             samples_held;
  smoothed_beat_t smoothed_due [$];
  int             fails;

  // Mode of the window centered at the given age, clipped to what is held.
  function automatic code_t mode_at(input int center);
    int    tally [NUM_CODES+1];
    int    lo;
    int    hi;
    int    best_n;
    code_t best;
    foreach (tally[i]) tally[i] = 0;
    best   = '0;
    best_n = 0;
    if (samples_held == 0) return '0;
    lo = (center > HALF_SPAN) ? center - HALF_SPAN : 0;
    hi = center + HALF_SPAN;
    if (hi > samples_held - 1) hi = samples_held - 1;
    for (int a = lo; a <= hi && a < FULL_SPAN; a++) begin
      if (window_q[a] >= 1 && window_q[a] <= NUM_CODES) tally[window_q[a]]++;
    end
    for (int c = 1; c <= NUM_CODES; c++) begin
      if (tally[c] > best_n) begin
        best_n = tally[c];
        best   = code_t'(c);
      end
    end
    return best;
  endfunction

  function automatic void clear_window();
    foreach (window_q[i]) window_q[i] = '0;
    samples_held = 0;
  endfunction

  // Shift one sample in and queue the smoothed codes it releases.
  function automatic void predict_smoothed(input code_t dir, input logic last);
    smoothed_beat_t b;
    int             flush_n;
    if (dir > NUM_CODES) dir = '0;
    for (int a = FULL_SPAN - 1; a > 0; a--) window_q[a] = window_q[a-1];
    window_q[0] = dir;
    if (samples_held < FULL_SPAN) samples_held++;
    if (!last) begin
      if (samples_held >= HALF_SPAN + 1) begin
        b.smoothed   = mode_at(HALF_SPAN);
        b.end_of_run = 1'b0;
        smoothed_due.push_back(b);
      end
    end else begin
      flush_n = (samples_held < HALF_SPAN + 1) ? samples_held : HALF_SPAN + 1;
      for (int c = flush_n - 1; c >= 0; c--) begin
        b.smoothed   = mode_at(c);
        b.end_of_run = (c == 0);
        smoothed_due.push_back(b);
      end
      clear_window();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_window();
      smoothed_due.delete();
      fails = 0;
    end else begin
      if (sample_valid && !sample_stall) predict_smoothed(direction, is_last);
      if (result_valid && !result_stall) begin
        if (smoothed_due.size() == 0) begin
          $error("unexpected result beat: smoothed=%0d end_of_run=%0d",
                 smoothed, end_of_run);
          fails++;
        end else begin
          if (smoothed !== smoothed_due[0].smoothed) begin
            $error("smoothed: expected %0d, got %0d", smoothed_due[0].smoothed, smoothed);
            fails++;
          end
          if (end_of_run !== smoothed_due[0].end_of_run) begin
            $error("end_of_run: expected %0d, got %0d",
                   smoothed_due[0].end_of_run, end_of_run);
            fails++;
          end
          void'(smoothed_due.pop_front());
        end
      end
    end
    fail_count <= fails;
    pending    <= smoothed_due.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import swmf_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  // Cycles to hold after the last expected beat, to catch stray results.
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_BEATS  = 480;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_EVERY3, STALL_HEAVY} stall_mode_t;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  sample_valid = 1'b0;
  logic  sample_stall;
  code_t direction    = '0;
  logic  is_last      = 1'b0;
  logic  result_valid;
  logic  result_stall = 1'b0;
  code_t smoothed;
  logic  end_of_run;

  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  sliding_window_mode_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .direction    (direction),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .smoothed     (smoothed),
    .end_of_run   (end_of_run)
  );

  mode_filter_checker mode_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .direction    (direction),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .smoothed     (smoothed),
    .end_of_run   (end_of_run),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure: switch between a few stall patterns at random
  // intervals, including stretches that never stall at all.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   result_stall <= 1'b0;
      STALL_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
      STALL_EVERY3: result_stall <= (stall_left % 3 == 0);
      default:      result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample beat and hold it until it is taken. The sender works in
  // bursts; at the end of a burst drop valid for a gap before the next burst,
  // so valid is never lowered and raised in the same step.
  task automatic send_sample(input code_t dir, input logic last);
    if (burst_left == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Mostly short bursts; now and then a long one with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    sample_valid <= 1'b1;
    direction    <= dir;
    is_last      <= last;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    burst_left--;
    beats_sent++;
  endtask

  // One sequence of random length. Most draw from a small set of codes so
  // the window holds real majorities and ties; some are plain noise over the
  // whole code range, zeros included.
  task automatic send_sequence();
    int    len;
    int    pick;
    bit    noisy;
    code_t favorite;
    code_t second;
    code_t third;
    code_t dir;
    len      = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 30);
    noisy    = ($urandom_range(0, 6) == 0);
    favorite = code_t'($urandom_range(1, NUM_CODES));
    second   = code_t'($urandom_range(1, NUM_CODES));
    third    = code_t'($urandom_range(1, NUM_CODES));
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (noisy)          dir = code_t'($urandom_range(0, NUM_CODES));
      else if (pick == 0) dir = '0;
      else if (pick <= 5) dir = favorite;
      else if (pick <= 8) dir = second;
      else                dir = third;
      send_sample(dir, i == len - 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a lone sample, a sequence shorter than half a window,
    // a window of nothing but ignored zeros, and ties across a sequence
    // that runs past the window span.
    send_sample(4'd8, 1'b1);
    send_sample(4'd3, 1'b0);
    send_sample(4'd0, 1'b1);
    send_sample(4'd0, 1'b0);
    send_sample(4'd0, 1'b0);
    send_sample(4'd0, 1'b1);
    send_sample(4'd2, 1'b0);
    send_sample(4'd1, 1'b0);
    send_sample(4'd1, 1'b0);
    send_sample(4'd2, 1'b0);
    send_sample(4'd5, 1'b0);
    send_sample(4'd5, 1'b0);
    send_sample(4'd8, 1'b0);
    send_sample(4'd8, 1'b0);
    send_sample(4'd3, 1'b1);
    send_sample(4'd7, 1'b0);
    send_sample(4'd4, 1'b0);
    send_sample(4'd6, 1'b1);
    send_sample(4'd1, 1'b0);
    send_sample(4'd8, 1'b0);
    send_sample(4'd0, 1'b0);
    send_sample(4'd8, 1'b0);
    send_sample(4'd1, 1'b1);

    // Random sequences until enough sample beats have gone in; the last
    // sequence always closes with a last beat so everything flushes.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) send_sequence();
    sample_valid <= 1'b0;

    // Let the checker's count take in the final beat,
    // then wait for every prediction to be matched.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/swmf_pkg.sv
sv/swmf_window.sv
sv/swmf_mode.sv
sv/swmf_seq.sv
sv/sliding_window_mode_filter_top.sv
sv/swmf_port_checker.sv
tb/sv/mode_filter_checker.sv
tb/sv/tb.sv
